[design/sqt_pkg.sv]
// ----------------------------------------------------------------------------
// sqt_pkg
// Shared types, constants and helpers for the sprite quad transform.
// ----------------------------------------------------------------------------
package sqt_pkg;

  localparam int CoordW           = 24;
  localparam int SizeW            = 23;
  localparam int ScaleW           = 16;
  localparam int AngleW           = 16;
  localparam int SineTableEntries = 1024;
  localparam int SinOne           = 16384;
  localparam int RndHalf          = 1 << 21;
  localparam int CornW            = 38;   // unsaturated corner, 8 fraction bits
  localparam int WideW            = 40;   // corner four before saturation

  localparam logic [63:0] Q30HalfPi = 64'd1686629713;

  localparam logic signed [WideW-1:0] CoordMax = WideW'(64'sd8388607);
  localparam logic signed [WideW-1:0] CoordMin = -WideW'(64'sd8388608);

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] size_w;
    logic signed [CoordW-1:0] size_h;
    logic signed [CoordW-1:0] pivot_x;
    logic signed [CoordW-1:0] pivot_y;
    logic signed [ScaleW-1:0] scale_x;
    logic signed [ScaleW-1:0] scale_y;
    logic [AngleW-1:0]        angle;
  } sprite_t;

  typedef struct packed {
    logic signed [CoordW-1:0] corner1_x;
    logic signed [CoordW-1:0] corner1_y;
    logic signed [CoordW-1:0] corner2_x;
    logic signed [CoordW-1:0] corner2_y;
    logic signed [CoordW-1:0] corner3_x;
    logic signed [CoordW-1:0] corner3_y;
    logic signed [CoordW-1:0] corner4_x;
    logic signed [CoordW-1:0] corner4_y;
    logic signed [CoordW-1:0] box_min_x;
    logic signed [CoordW-1:0] box_min_y;
    logic [SizeW-1:0]         box_width;
    logic [SizeW-1:0]         box_height;
  } quad_t;

  // first three corners in world space, not yet saturated
  typedef struct packed {
    logic signed [CornW-1:0] c1x;
    logic signed [CornW-1:0] c1y;
    logic signed [CornW-1:0] c2x;
    logic signed [CornW-1:0] c2y;
    logic signed [CornW-1:0] c3x;
    logic signed [CornW-1:0] c3y;
  } corner_set_t;

  function automatic logic signed [CoordW-1:0] sat_coord(logic signed [WideW-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v > CoordMax) begin
      r = CoordW'(CoordMax);
    end else if (v < CoordMin) begin
      r = CoordW'(CoordMin);
    end else begin
      r = CoordW'(v);
    end
    return r;
  endfunction

endpackage

[design/sqt_sine_rom.sv]
// ----------------------------------------------------------------------------
// sqt_sine_rom
// Quarter-wave sine table, two registered read ports giving sin and cos
// magnitudes (Q1.14) and their signs for one angle.
// ----------------------------------------------------------------------------
module sqt_sine_rom #(
  parameter int SineEntries = sqt_pkg::SineTableEntries
) (
  input  logic                       clk_i,
  input  logic [sqt_pkg::AngleW-1:0] angle_i,
  output logic [14:0]                s_mag_o,
  output logic [14:0]                c_mag_o,
  output logic                       s_neg_o,
  output logic                       c_neg_o
);

  localparam int IdxW  = $clog2(SineEntries + 1);
  localparam int ProdW = 15 + IdxW;

  typedef logic [14:0] rom_t [SineEntries+1];

  // Taylor series through x^15 in Q30, rounded to Q14
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    for (int k = 0; k <= SineEntries; k++) begin
      x    = (64'(k) * sqt_pkg::Q30HalfPi) / 64'(SineEntries);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      v = (sum + 64'sd32768) >>> 16;
      if (v > 64'(sqt_pkg::SinOne)) begin
        v = 64'(sqt_pkg::SinOne);
      end
      rom[k] = 15'(v);
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [1:0]      quad;
  logic [13:0]     frac;
  logic [14:0]     fwd;
  logic [14:0]     rev;
  logic [ProdW-1:0] fwd_prod;
  logic [ProdW-1:0] rev_prod;
  logic [IdxW-1:0] fwd_idx;
  logic [IdxW-1:0] rev_idx;
  logic [1:0]      quad_c;
  logic [14:0]     s_mag_q;
  logic [14:0]     c_mag_q;
  logic            s_neg_q;
  logic            c_neg_q;

  assign quad     = angle_i[15:14];
  assign frac     = angle_i[13:0];
  assign quad_c   = quad + 2'd1;
  assign fwd      = {1'b0, frac};
  assign rev      = 15'(sqt_pkg::SinOne) - fwd;
  assign fwd_prod = ProdW'(fwd) * ProdW'(SineEntries);
  assign rev_prod = ProdW'(rev) * ProdW'(SineEntries);
  assign fwd_idx  = fwd_prod[14 +: IdxW];
  assign rev_idx  = rev_prod[14 +: IdxW];

  // odd quadrants read the table backwards; cos sits one quadrant ahead
  always_ff @(posedge clk_i) begin
    s_mag_q <= quad[0] ? SineRom[rev_idx] : SineRom[fwd_idx];
    c_mag_q <= quad[0] ? SineRom[fwd_idx] : SineRom[rev_idx];
    s_neg_q <= quad[1];
    c_neg_q <= quad_c[1];
  end

  assign s_mag_o = s_mag_q;
  assign c_mag_o = c_mag_q;
  assign s_neg_o = s_neg_q;
  assign c_neg_o = c_neg_q;

endmodule

[design/sqt_rotate.sv]
// ----------------------------------------------------------------------------
// sqt_rotate
// Five-stage datapath: pivot-relative corners, scale, rotate, round and
// translate. Gives the first three world-space corners, unsaturated.
// ----------------------------------------------------------------------------
module sqt_rotate #(
  parameter int SineEntries = sqt_pkg::SineTableEntries
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  sqt_pkg::sprite_t     sprite_i,
  output logic                 valid_o,
  output sqt_pkg::corner_set_t corners_o
);

  localparam int LW = 26;   // local coordinate
  localparam int MW = 42;   // scaled local coordinate
  localparam int PW = 58;   // rotated product, 30 fraction bits
  localparam int AW = 59;   // sum of two products
  localparam int OW = 25;   // world origin

  logic [4:0] vld_q;

  // stage 1
  logic signed [LW-1:0] lx1_q, ly1_q, lx21_q, ly21_q;
  logic signed [OW-1:0] wx1_q, wy1_q;
  logic signed [sqt_pkg::ScaleW-1:0] sx1_q, sy1_q;
  logic [14:0] s_mag, c_mag;
  logic        s_neg, c_neg;
  // stage 2
  logic signed [MW-1:0] lx2_q, ly2_q, lx22_q, ly22_q;
  logic signed [15:0]   s2_q, c2_q;
  logic signed [OW-1:0] wx2_q, wy2_q;
  // stage 3
  logic signed [PW-1:0] lxc_q, lxs_q, lyc_q, lys_q;
  logic signed [PW-1:0] lx2c_q, lx2s_q, ly2c_q, ly2s_q;
  logic signed [OW-1:0] wx3_q, wy3_q;
  // stage 4
  logic signed [AW-1:0] ax1_q, ay1_q, ax2_q, ay2_q, ax3_q, ay3_q;
  logic signed [OW-1:0] wx4_q, wy4_q;
  // stage 5
  sqt_pkg::corner_set_t cs5_q;

  localparam logic signed [AW-1:0] Rnd = AW'(sqt_pkg::RndHalf);

  sqt_sine_rom #(
    .SineEntries(SineEntries)
  ) u_rom (
    .clk_i  (clk_i),
    .angle_i(sprite_i.angle),
    .s_mag_o(s_mag),
    .c_mag_o(c_mag),
    .s_neg_o(s_neg),
    .c_neg_o(c_neg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // floor(v / 2^22) after adding half, plus origin
  function automatic logic signed [sqt_pkg::CornW-1:0] place(
      logic signed [AW-1:0] v, logic signed [OW-1:0] w);
    logic signed [AW-1:0] sh;
    sh = v >>> 22;
    return sqt_pkg::CornW'(sh) + sqt_pkg::CornW'(w);
  endfunction

  always_ff @(posedge clk_i) begin
    // stage 1: pivot-relative edges and origin
    lx1_q  <= -LW'(sprite_i.pivot_x);
    ly1_q  <= -LW'(sprite_i.pivot_y);
    lx21_q <= LW'(sprite_i.size_w) - LW'(sprite_i.pivot_x);
    ly21_q <= LW'(sprite_i.size_h) - LW'(sprite_i.pivot_y);
    wx1_q  <= OW'(sprite_i.pos_x) + OW'(sprite_i.pivot_x);
    wy1_q  <= OW'(sprite_i.pos_y) + OW'(sprite_i.pivot_y);
    sx1_q  <= sprite_i.scale_x;
    sy1_q  <= sprite_i.scale_y;

    // stage 2: scale, signed sin and cos
    lx2_q  <= MW'(lx1_q) * MW'(sx1_q);
    lx22_q <= MW'(lx21_q) * MW'(sx1_q);
    ly2_q  <= MW'(ly1_q) * MW'(sy1_q);
    ly22_q <= MW'(ly21_q) * MW'(sy1_q);
    s2_q   <= s_neg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    c2_q   <= c_neg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
    wx2_q  <= wx1_q;
    wy2_q  <= wy1_q;

    // stage 3: rotation products
    lxc_q  <= PW'(lx2_q) * PW'(c2_q);
    lxs_q  <= PW'(lx2_q) * PW'(s2_q);
    lyc_q  <= PW'(ly2_q) * PW'(c2_q);
    lys_q  <= PW'(ly2_q) * PW'(s2_q);
    lx2c_q <= PW'(lx22_q) * PW'(c2_q);
    lx2s_q <= PW'(lx22_q) * PW'(s2_q);
    ly2c_q <= PW'(ly22_q) * PW'(c2_q);
    ly2s_q <= PW'(ly22_q) * PW'(s2_q);
    wx3_q  <= wx2_q;
    wy3_q  <= wy2_q;

    // stage 4: combine, with half an output lsb for rounding
    ax1_q <= AW'(lxc_q) - AW'(lys_q) + Rnd;
    ay1_q <= AW'(lyc_q) + AW'(lxs_q) + Rnd;
    ax2_q <= AW'(lxc_q) - AW'(ly2s_q) + Rnd;
    ay2_q <= AW'(ly2c_q) + AW'(lxs_q) + Rnd;
    ax3_q <= AW'(lx2c_q) - AW'(ly2s_q) + Rnd;
    ay3_q <= AW'(ly2c_q) + AW'(lx2s_q) + Rnd;
    wx4_q <= wx3_q;
    wy4_q <= wy3_q;

    // stage 5: to Q.8 and into world space
    cs5_q.c1x <= place(ax1_q, wx4_q);
    cs5_q.c1y <= place(ay1_q, wy4_q);
    cs5_q.c2x <= place(ax2_q, wx4_q);
    cs5_q.c2y <= place(ay2_q, wy4_q);
    cs5_q.c3x <= place(ax3_q, wx4_q);
    cs5_q.c3y <= place(ay3_q, wy4_q);
  end

  assign valid_o   = vld_q[4];
  assign corners_o = cs5_q;

endmodule

[design/sqt_bound.sv]
// ----------------------------------------------------------------------------
// sqt_bound
// Fourth corner, saturation and bounding box over four stages; the last
// stage is the output register.
// ----------------------------------------------------------------------------
module sqt_bound (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  sqt_pkg::corner_set_t corners_i,
  output logic                 done_o,
  output sqt_pkg::quad_t       quad_o
);

  localparam int CW = sqt_pkg::CoordW;
  localparam int WW = sqt_pkg::WideW;
  localparam int DW = CW + 1;

  logic [3:0] vld_q;

  logic signed [CW-1:0] cx6_q [4];
  logic signed [CW-1:0] cy6_q [4];
  logic signed [CW-1:0] cx7_q [4];
  logic signed [CW-1:0] cy7_q [4];
  logic signed [CW-1:0] cx8_q [4];
  logic signed [CW-1:0] cy8_q [4];

  logic signed [CW-1:0] mnx01_q, mnx23_q, mxx01_q, mxx23_q;
  logic signed [CW-1:0] mny01_q, mny23_q, mxy01_q, mxy23_q;
  logic signed [CW-1:0] mnx_q, mxx_q, mny_q, mxy_q;

  logic signed [WW-1:0] c4x, c4y;
  logic signed [DW-1:0] span_x, span_y;

  sqt_pkg::quad_t quad_q;

  // corner four from the unsaturated corners
  assign c4x = WW'(corners_i.c1x) + WW'(corners_i.c3x) - WW'(corners_i.c2x);
  assign c4y = WW'(corners_i.c3y) - WW'(corners_i.c2y) + WW'(corners_i.c1y);

  assign span_x = DW'(mxx_q) - DW'(mnx_q);
  assign span_y = DW'(mxy_q) - DW'(mny_q);

  function automatic logic signed [CW-1:0] smin(logic signed [CW-1:0] a,
                                                logic signed [CW-1:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [CW-1:0] smax(logic signed [CW-1:0] a,
                                                logic signed [CW-1:0] b);
    return (b > a) ? b : a;
  endfunction

  function automatic logic [sqt_pkg::SizeW-1:0] sat_span(logic signed [DW-1:0] v);
    return v[DW-1:sqt_pkg::SizeW] != '0 ? '1 : v[sqt_pkg::SizeW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 6: saturate
    cx6_q[0] <= sqt_pkg::sat_coord(WW'(corners_i.c1x));
    cy6_q[0] <= sqt_pkg::sat_coord(WW'(corners_i.c1y));
    cx6_q[1] <= sqt_pkg::sat_coord(WW'(corners_i.c2x));
    cy6_q[1] <= sqt_pkg::sat_coord(WW'(corners_i.c2y));
    cx6_q[2] <= sqt_pkg::sat_coord(WW'(corners_i.c3x));
    cy6_q[2] <= sqt_pkg::sat_coord(WW'(corners_i.c3y));
    cx6_q[3] <= sqt_pkg::sat_coord(c4x);
    cy6_q[3] <= sqt_pkg::sat_coord(c4y);

    // stage 7: pairwise extremes
    mnx01_q <= smin(cx6_q[0], cx6_q[1]);
    mnx23_q <= smin(cx6_q[2], cx6_q[3]);
    mxx01_q <= smax(cx6_q[0], cx6_q[1]);
    mxx23_q <= smax(cx6_q[2], cx6_q[3]);
    mny01_q <= smin(cy6_q[0], cy6_q[1]);
    mny23_q <= smin(cy6_q[2], cy6_q[3]);
    mxy01_q <= smax(cy6_q[0], cy6_q[1]);
    mxy23_q <= smax(cy6_q[2], cy6_q[3]);
    cx7_q   <= cx6_q;
    cy7_q   <= cy6_q;

    // stage 8: final extremes
    mnx_q <= smin(mnx01_q, mnx23_q);
    mxx_q <= smax(mxx01_q, mxx23_q);
    mny_q <= smin(mny01_q, mny23_q);
    mxy_q <= smax(mxy01_q, mxy23_q);
    cx8_q <= cx7_q;
    cy8_q <= cy7_q;

    // stage 9: extents and output word
    quad_q.corner1_x  <= cx8_q[0];
    quad_q.corner1_y  <= cy8_q[0];
    quad_q.corner2_x  <= cx8_q[1];
    quad_q.corner2_y  <= cy8_q[1];
    quad_q.corner3_x  <= cx8_q[2];
    quad_q.corner3_y  <= cy8_q[2];
    quad_q.corner4_x  <= cx8_q[3];
    quad_q.corner4_y  <= cy8_q[3];
    quad_q.box_min_x  <= mnx_q;
    quad_q.box_min_y  <= mny_q;
    quad_q.box_width  <= sat_span(span_x);
    quad_q.box_height <= sat_span(span_y);
  end

  assign done_o = vld_q[3];
  assign quad_o = quad_q;

endmodule

[design/sprite_quad_transform.sv]
// Pipeline: nine register stages, fully pipelined; done_o is high for a single cycle
// with each result, which quad_o holds in that cycle.
// Throughput: one sprite per clock; busy is never raised since the receiver
// cannot stall and every stage advances each cycle.
// Reset: rst_ni clears the stage valid bits asynchronously; no result strobes
// until a word is accepted. The sine table is a constant ROM, ready at once.
// ----------------------------------------------------------------------------
// sprite_quad_transform
// World-space corners and bounding box of a scaled, rotated sprite quad.
// ----------------------------------------------------------------------------
module sprite_quad_transform #(
  parameter int SineTableEntries = sqt_pkg::SineTableEntries
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  sqt_pkg::sprite_t sprite_i,
  output logic             done_o,
  output sqt_pkg::quad_t   quad_o
);

  logic                 accept;
  logic                 rot_vld;
  sqt_pkg::corner_set_t rot_corners;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  sqt_rotate #(
    .SineEntries(SineTableEntries)
  ) u_rotate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .sprite_i (sprite_i),
    .valid_o  (rot_vld),
    .corners_o(rot_corners)
  );

  sqt_bound u_bound (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rot_vld),
    .corners_i(rot_corners),
    .done_o   (done_o),
    .quad_o   (quad_o)
  );

endmodule
